[rtl/grid_ray_free_space_trace_defines.svh]
// ----------------------------------------------------------------------------
// grid ray trace assertion macros
// concurrent assertion shorthands clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef GRID_RAY_FREE_SPACE_TRACE_DEFINES_SVH
`define GRID_RAY_FREE_SPACE_TRACE_DEFINES_SVH

// same-cycle implication
`define GRT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/grt_pkg.sv]
// ----------------------------------------------------------------------------
// grt_pkg
// shared types and codes of the occupancy grid ray tracer
// ----------------------------------------------------------------------------
package grt_pkg;

    localparam int COORD_W = 8;
    localparam int CELL_W  = 8;
    localparam int CFG_W   = 9;
    localparam int FREED_W = 9;
    localparam int CFGI_W  = 2;

    // item modes
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_TRACE = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_BLOCKED = 2'd1;
    localparam logic [1:0] STAT_RANGE   = 2'd2;

    // configuration register indexes
    localparam logic [CFGI_W-1:0] REG_ROWS = 2'd0;
    localparam logic [CFGI_W-1:0] REG_COLS = 2'd1;

    // cell values
    localparam logic [CELL_W-1:0] CELL_UNKNOWN = 8'hFF;
    localparam logic [CELL_W-1:0] CELL_FREE    = 8'h00;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_ACCESS,
        ST_RDATA,
        ST_TRACE,
        ST_DONE
    } grt_state_t;

endpackage

[rtl/grt_ram.sv]
// ----------------------------------------------------------------------------
// grt_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module grt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/grid_ray_free_space_trace.sv]
// ----------------------------------------------------------------------------
// grid_ray_free_space_trace
// occupancy grid with cell write, cell read and bresenham free-space trace
// ----------------------------------------------------------------------------
//  channel   signals                                          direction
//  input     in_valid/in_ready, mode, start_row, start_col,   in
//            end_row, end_col, write_value
//  output    out_valid/out_ready, cell_value, status,         out
//            cells_freed
//  config    cfg_valid/cfg_ready, cfg_index, cfg_data         in
//
//  a trace visits span cells from the start, span the larger row/column
//  distance (none for start equal to end, up to the k-th cell when that
//  cell is an obstacle); one cell a cycle on the single read and single
//  write port of the grid ram
//  after reset a clearing pass writes unknown to all MAX_ROWS * MAX_COLS
//  cells, one a cycle; no word is accepted until it ends
//  a finished result waits in the output register, the next word is accepted
//  meanwhile; a new result stalls only while that register is still full
// ----------------------------------------------------------------------------
module grid_ray_free_space_trace
    import grt_pkg::*;
#(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // input words
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                mode,
    input  logic [COORD_W-1:0]        start_row,
    input  logic [COORD_W-1:0]        start_col,
    input  logic [COORD_W-1:0]        end_row,
    input  logic [COORD_W-1:0]        end_col,
    input  logic signed [CELL_W-1:0]  write_value,
    // result words
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [CELL_W-1:0]  cell_value,
    output logic [1:0]                status,
    output logic [FREED_W-1:0]        cells_freed,
    // configuration writes
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFGI_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]          cfg_data
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    // register values above the grid size clamp to it; above 511 they never do
    localparam logic [CFG_W-1:0] ROWS_CAP = CFG_W'((MAX_ROWS > 511) ? 511 : MAX_ROWS);
    localparam logic [CFG_W-1:0] COLS_CAP = CFG_W'((MAX_COLS > 511) ? 511 : MAX_COLS);
    localparam logic [AW-1:0]    LAST_ADDR = AW'(DEPTH - 1);
    localparam int SUM_W = COORD_W + CFG_W + 1;

    grt_state_t state_reg, state_next;

    // configuration
    logic [CFG_W-1:0] rows_reg, rows_next;
    logic [CFG_W-1:0] cols_reg, cols_next;
    logic [CFG_W-1:0] eff_rows, eff_cols;

    // clearing pass
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic          clr_last;

    // latched item
    logic [1:0]         mode_reg, mode_next;
    logic [COORD_W-1:0] sr_reg, sr_next;
    logic [COORD_W-1:0] sc_reg, sc_next;
    logic [COORD_W-1:0] er_reg, er_next;
    logic [COORD_W-1:0] ec_reg, ec_next;
    logic [CELL_W-1:0]  wv_reg, wv_next;
    logic               oor_reg, oor_next;
    logic               start_oor, end_oor;

    // walker state
    logic [AW-1:0]         addr_reg, addr_next;
    logic [AW-1:0]         maj_delta_reg, maj_delta_next;
    logic [AW-1:0]         min_delta_reg, min_delta_next;
    logic [COORD_W:0]      derr_reg, derr_next;
    logic [COORD_W-1:0]    span_reg, span_next;
    logic signed [10:0]    err_reg, err_next;
    logic [COORD_W-1:0]    left_reg, left_next;
    logic                  chk_vld_reg, chk_vld_next;
    logic [AW-1:0]         chk_addr_reg, chk_addr_next;

    // result staging and output register
    logic [CELL_W-1:0]  res_value_reg, res_value_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic [FREED_W-1:0] freed_reg, freed_next;
    logic               out_valid_reg, out_valid_next;
    logic [CELL_W-1:0]  out_value_reg, out_value_next;
    logic [1:0]         out_status_reg, out_status_next;
    logic [FREED_W-1:0] out_freed_reg, out_freed_next;

    // setup arithmetic
    logic [SUM_W-1:0]     start_sum;
    logic [AW-1:0]        start_addr;
    logic signed [COORD_W:0] drow, dcol;
    logic [COORD_W-1:0]   adrow, adcol;
    logic                 transposed;
    logic [AW-1:0]        cols_aw;
    logic signed [10:0]   err_sum;
    logic                 min_step;

    // ram ports
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [CELL_W-1:0] mem_wdata, mem_rdata;

    logic in_fire, cfg_fire, out_load, blocked, issue, walk_end;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    assign out_valid   = out_valid_reg;
    assign cell_value  = out_value_reg;
    assign status      = out_status_reg;
    assign cells_freed = out_freed_reg;

    assign eff_rows = (rows_reg > ROWS_CAP) ? ROWS_CAP : rows_reg;
    assign eff_cols = (cols_reg > COLS_CAP) ? COLS_CAP : cols_reg;
    assign cols_aw  = AW'(eff_cols);
    assign clr_last = (clr_addr_reg == LAST_ADDR);

    // range checks on the incoming word
    assign start_oor = ({1'b0, start_row} >= eff_rows) || ({1'b0, start_col} >= eff_cols);
    assign end_oor   = ({1'b0, end_row} >= eff_rows) || ({1'b0, end_col} >= eff_cols);

    // start cell address, row major with the configured stride
    assign start_sum  = SUM_W'(sr_reg) * SUM_W'(eff_cols) + SUM_W'(sc_reg);
    assign start_addr = AW'(start_sum);

    // bresenham setup: major axis has the larger span, columns win a tie
    assign drow       = $signed({1'b0, er_reg}) - $signed({1'b0, sr_reg});
    assign dcol       = $signed({1'b0, ec_reg}) - $signed({1'b0, sc_reg});
    assign adrow      = drow[COORD_W] ? COORD_W'(-drow) : drow[COORD_W-1:0];
    assign adcol      = dcol[COORD_W] ? COORD_W'(-dcol) : dcol[COORD_W-1:0];
    assign transposed = (adcol < adrow);
    // minor step is negative when its difference is negative
    assign min_step   = transposed ? dcol[COORD_W] : drow[COORD_W];

    assign err_sum = err_reg + $signed({2'b00, derr_reg});

    // walk pipeline: the cell read last cycle is checked while the next one is
    // read; a line never revisits a cell so the two never share an address
    assign blocked  = chk_vld_reg && !mem_rdata[CELL_W-1] && (mem_rdata != CELL_FREE);
    assign issue    = (left_reg != '0) && !blocked;
    assign walk_end = blocked || ((left_reg == '0) && !chk_vld_reg);

    grt_ram #(
        .WIDTH(CELL_W),
        .DEPTH(DEPTH)
    ) u_grt_ram (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (clr_last) state_next = ST_IDLE;
            ST_IDLE:   if (in_valid) state_next = ST_CALC;
            ST_CALC:
            begin
                if (oor_reg || (mode_reg == MODE_NONE))
                    state_next = ST_DONE;
                else if (mode_reg == MODE_TRACE)
                    state_next = ST_TRACE;
                else
                    state_next = ST_ACCESS;
            end
            ST_ACCESS: state_next = (mode_reg == MODE_WRITE) ? ST_DONE : ST_RDATA;
            ST_RDATA:  state_next = ST_DONE;
            ST_TRACE:  if (walk_end) state_next = ST_DONE;
            ST_DONE:   if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // state outputs: handshake and ram controls
    always_comb
    begin
        in_ready  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = wv_reg;
        mem_re    = 1'b0;
        mem_raddr = addr_reg;
        unique case (state_reg) inside
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = CELL_UNKNOWN;
            end
            ST_IDLE:   in_ready = 1'b1;
            ST_ACCESS:
            begin
                mem_we = (mode_reg == MODE_WRITE);
                mem_re = (mode_reg == MODE_READ);
            end
            ST_TRACE:
            begin
                mem_we    = chk_vld_reg && !blocked;
                mem_waddr = chk_addr_reg;
                mem_wdata = CELL_FREE;
                mem_re    = issue;
            end
            ST_CALC, ST_RDATA, ST_DONE: ;
            default: ;
        endcase
    end

    // datapath next values
    always_comb
    begin
        rows_next       = rows_reg;
        cols_next       = cols_reg;
        clr_addr_next   = clr_addr_reg;
        mode_next       = mode_reg;
        sr_next         = sr_reg;
        sc_next         = sc_reg;
        er_next         = er_reg;
        ec_next         = ec_reg;
        wv_next         = wv_reg;
        oor_next        = oor_reg;
        addr_next       = addr_reg;
        maj_delta_next  = maj_delta_reg;
        min_delta_next  = min_delta_reg;
        derr_next       = derr_reg;
        span_next       = span_reg;
        err_next        = err_reg;
        left_next       = left_reg;
        chk_vld_next    = 1'b0;
        chk_addr_next   = chk_addr_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        freed_next      = freed_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_freed_next  = out_freed_reg;

        if (cfg_fire)
        begin
            case (cfg_index)
                REG_ROWS: rows_next = cfg_data;
                REG_COLS: cols_next = cfg_data;
                default: ;
            endcase
        end

        if (state_reg == ST_CLEAR)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
        end

        if (in_fire)
        begin
            mode_next = mode;
            sr_next   = start_row;
            sc_next   = start_col;
            er_next   = end_row;
            ec_next   = end_col;
            wv_next   = write_value;
            case (mode) inside
                MODE_WRITE, MODE_READ: oor_next = start_oor;
                MODE_TRACE:            oor_next = start_oor || end_oor;
                default:               oor_next = 1'b0;
            endcase
        end

        if (state_reg == ST_CALC)
        begin
            addr_next       = start_addr;
            res_value_next  = '0;
            res_status_next = oor_reg ? STAT_RANGE : STAT_DONE;
            freed_next      = '0;
            span_next       = transposed ? adrow : adcol;
            left_next       = transposed ? adrow : adcol;
            derr_next       = {transposed ? adcol : adrow, 1'b0};
            err_next        = '0;
            if (transposed)
            begin
                maj_delta_next = drow[COORD_W] ? -cols_aw : cols_aw;
                min_delta_next = min_step ? '1 : AW'(1);
            end
            else
            begin
                maj_delta_next = dcol[COORD_W] ? '1 : AW'(1);
                min_delta_next = min_step ? -cols_aw : cols_aw;
            end
        end

        if (state_reg == ST_RDATA)
        begin
            res_value_next = mem_rdata;
        end

        if (state_reg == ST_TRACE)
        begin
            if (blocked)
            begin
                res_status_next = STAT_BLOCKED;
            end
            else if (chk_vld_reg)
            begin
                freed_next = freed_reg + 1'b1;
            end
            if (issue)
            begin
                chk_vld_next  = 1'b1;
                chk_addr_next = addr_reg;
                left_next     = left_reg - 1'b1;
                if (err_sum > $signed({3'b000, span_reg}))
                begin
                    addr_next = addr_reg + maj_delta_reg + min_delta_reg;
                    err_next  = err_sum - $signed({2'b00, span_reg, 1'b0});
                end
                else
                begin
                    addr_next = addr_reg + maj_delta_reg;
                    err_next  = err_sum;
                end
            end
        end

        // output register
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_value_next  = res_value_reg;
            out_status_next = res_status_reg;
            out_freed_next  = freed_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            rows_reg      <= CFG_W'(256);
            cols_reg      <= CFG_W'(256);
            clr_addr_reg  <= '0;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rows_reg      <= rows_next;
            cols_reg      <= cols_next;
            clr_addr_reg  <= clr_addr_next;
            chk_vld_reg   <= chk_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        sr_reg         <= sr_next;
        sc_reg         <= sc_next;
        er_reg         <= er_next;
        ec_reg         <= ec_next;
        wv_reg         <= wv_next;
        oor_reg        <= oor_next;
        addr_reg       <= addr_next;
        maj_delta_reg  <= maj_delta_next;
        min_delta_reg  <= min_delta_next;
        derr_reg       <= derr_next;
        span_reg       <= span_next;
        err_reg        <= err_next;
        left_reg       <= left_next;
        chk_addr_reg   <= chk_addr_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        freed_reg      <= freed_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_freed_reg  <= out_freed_next;
    end

endmodule

[rtl/grt_checker.sv]
// ----------------------------------------------------------------------------
// grt_checker
// port-level checks of the grid ray tracer, bound to the top level
// ----------------------------------------------------------------------------
`include "grid_ray_free_space_trace_defines.svh"

module grt_checker
    import grt_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic [1:0]                mode,
    input logic [COORD_W-1:0]        start_row,
    input logic [COORD_W-1:0]        start_col,
    input logic [COORD_W-1:0]        end_row,
    input logic [COORD_W-1:0]        end_col,
    input logic signed [CELL_W-1:0]  write_value,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic signed [CELL_W-1:0]  cell_value,
    input logic [1:0]                status,
    input logic [FREED_W-1:0]        cells_freed,
    input logic                      cfg_valid,
    input logic                      cfg_ready,
    input logic [CFGI_W-1:0]         cfg_index,
    input logic [CFG_W-1:0]          cfg_data
);

    // a stalled result word holds
    `GRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(cells_freed) && $stable(cell_value), "result word changed while stalled")

    // one item in flight: no accept right after an accept
    `GRT_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "input accepted twice in a row")

    // only a read reports a cell value
    `GRT_ASSERT_NOW(a_value_zero, out_valid && (status != STAT_DONE), cell_value == '0, "cell value on a failed or blocked item")

    // a range error frees nothing
    `GRT_ASSERT_NOW(a_range_free, out_valid && (status == STAT_RANGE), cells_freed == '0, "cells freed on a range error")

endmodule

bind grid_ray_free_space_trace grt_checker u_grt_checker (.*);

[sim/grid_ray_free_space_trace_chk.sv]
// ----------------------------------------------------------------------------
// grid_ray_free_space_trace_chk
// watches the input, result and configuration channels of the grid ray
// tracer, keeps its own copy of the grid and compares every result word
// ----------------------------------------------------------------------------
module grid_ray_free_space_trace_chk
    import grt_pkg::*;
#(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic [1:0]                mode,
    input  logic [COORD_W-1:0]        start_row,
    input  logic [COORD_W-1:0]        start_col,
    input  logic [COORD_W-1:0]        end_row,
    input  logic [COORD_W-1:0]        end_col,
    input  logic signed [CELL_W-1:0]  write_value,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic signed [CELL_W-1:0]  cell_value,
    input  logic [1:0]                status,
    input  logic [FREED_W-1:0]        cells_freed,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFGI_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    output int                        fail_count,
    output int                        outstanding,
    output int                        blocked_count,
    output int                        range_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int MAX_REPORTS = 40;
    localparam logic [CFG_W-1:0] SHAPE_RESET = 9'd256;

    typedef struct packed {
        logic signed [CELL_W-1:0] cell_value;
        logic [1:0]               status;
        logic [FREED_W-1:0]       cells_freed;
    } grid_result_t;

    logic [CELL_W-1:0] grid_cells [CELLS];
    logic [CFG_W-1:0]  rows_shadow;
    logic [CFG_W-1:0]  cols_shadow;
    grid_result_t      awaited_results [$];
    int                results_seen;

    function automatic int mag(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int cell_index(int row, int col, int cols);
        int a;
        a = row * cols + col;
        return (a < CELLS) ? a : 0;
    endfunction

    // applies one word to the grid copy and returns the result it should give
    function automatic grid_result_t apply_grid_word(logic [1:0] op, int sr, int sc,
                                                     int er, int ec,
                                                     logic [CELL_W-1:0] wv);
        grid_result_t res;
        int rows, cols, drow, dcol, maj, maj_end, mnr, dmaj, dmin;
        int span, derr, err, maj_step, min_step, r, c, a, freed;
        bit steep, blocked;
        rows = (int'(rows_shadow) > MAX_ROWS) ? MAX_ROWS : int'(rows_shadow);
        cols = (int'(cols_shadow) > MAX_COLS) ? MAX_COLS : int'(cols_shadow);
        res = '0;
        freed = 0;
        case (op)
            MODE_WRITE, MODE_READ:
            begin
                if (sr >= rows || sc >= cols)
                    res.status = STAT_RANGE;
                else if (op == MODE_WRITE)
                    grid_cells[cell_index(sr, sc, cols)] = wv;
                else
                    res.cell_value = grid_cells[cell_index(sr, sc, cols)];
            end
            MODE_TRACE:
            begin
                if (sr >= rows || sc >= cols || er >= rows || ec >= cols)
                begin
                    res.status = STAT_RANGE;
                end
                else
                begin
                    drow = er - sr;
                    dcol = ec - sc;
                    // columns are the major axis on a tie
                    steep = mag(dcol) < mag(drow);
                    maj = steep ? sr : sc;
                    maj_end = steep ? er : ec;
                    mnr = steep ? sc : sr;
                    dmaj = steep ? drow : dcol;
                    dmin = steep ? dcol : drow;
                    span = mag(dmaj);
                    derr = 2 * mag(dmin);
                    err = 0;
                    maj_step = (dmaj > 0) ? 1 : -1;
                    min_step = (dmin > 0) ? 1 : -1;
                    blocked = 1'b0;
                    // end cell is never visited
                    while (maj != maj_end && !blocked)
                    begin
                        r = steep ? maj : mnr;
                        c = steep ? mnr : maj;
                        a = cell_index(r, c, cols);
                        if ($signed(grid_cells[a]) > 0)
                        begin
                            blocked = 1'b1;
                            res.status = STAT_BLOCKED;
                        end
                        else
                        begin
                            grid_cells[a] = CELL_FREE;
                            if (freed < 511)
                                freed++;
                            err += derr;
                            if (err > span)
                            begin
                                mnr += min_step;
                                err -= 2 * span;
                            end
                            maj += maj_step;
                        end
                    end
                end
            end
            default: ;
        endcase
        res.cells_freed = freed[FREED_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("chk: result %0d: %s", results_seen, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        grid_result_t want;
        grid_result_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < CELLS; i++)
                grid_cells[i] = CELL_UNKNOWN;
            rows_shadow = SHAPE_RESET;
            cols_shadow = SHAPE_RESET;
            awaited_results.delete();
            results_seen = 0;
            fail_count = 0;
            blocked_count = 0;
            range_count = 0;
            outstanding <= 0;
        end
        else
        begin
            // results first: a word taken at this edge cannot finish at it
            if (out_valid && out_ready)
            begin
                got = '{cell_value, status, cells_freed};
                if (awaited_results.size() == 0)
                begin
                    report_mismatch("result word with nothing awaited");
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.cell_value !== want.cell_value)
                        report_mismatch($sformatf("cell_value %0d, expected %0d",
                                                  got.cell_value, want.cell_value));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  got.status, want.status));
                    if (got.cells_freed !== want.cells_freed)
                        report_mismatch($sformatf("cells_freed %0d, expected %0d",
                                                  got.cells_freed, want.cells_freed));
                end
                results_seen++;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_ROWS)
                    rows_shadow = cfg_data;
                else if (cfg_index == REG_COLS)
                    cols_shadow = cfg_data;
            end
            if (in_valid && in_ready)
            begin
                want = apply_grid_word(mode, int'(start_row), int'(start_col),
                                       int'(end_row), int'(end_col), write_value);
                if (want.status == STAT_BLOCKED)
                    blocked_count++;
                if (want.status == STAT_RANGE)
                    range_count++;
                awaited_results.push_back(want);
            end
            outstanding <= awaited_results.size();
        end
    end

endmodule

[sim/grid_ray_free_space_trace_tb.sv]
// ----------------------------------------------------------------------------
// grid_ray_free_space_trace_tb
// drives cell writes, cell reads and ray traces into the grid ray tracer
// under several grid shapes and idle mixes; a checker beside the block
// predicts every result word and counts differences
// ----------------------------------------------------------------------------
module grid_ray_free_space_trace_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import grt_pkg::*;

    localparam int GRID_SIDE = 256;
    // a full grid side plus a margin, to cover a trace across the grid
    localparam int DRAIN_CYCLES = GRID_SIDE + 16;
    localparam int PHASES = 11;
    // register indexes the block has no register behind
    localparam logic [CFGI_W-1:0] REG_SPARE2 = 2'd2;
    localparam logic [CFGI_W-1:0] REG_SPARE3 = 2'd3;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mix_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [1:0]                mode;
    logic [COORD_W-1:0]        start_row;
    logic [COORD_W-1:0]        start_col;
    logic [COORD_W-1:0]        end_row;
    logic [COORD_W-1:0]        end_col;
    logic signed [CELL_W-1:0]  write_value;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [CELL_W-1:0]  cell_value;
    logic [1:0]                status;
    logic [FREED_W-1:0]        cells_freed;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFGI_W-1:0]         cfg_index;
    logic [CFG_W-1:0]          cfg_data;

    int fail_count;
    int outstanding;
    int blocked_count;
    int range_count;

    // idle chances in percent, read by the sender task and the receiver
    int send_idle_pct;
    int recv_stall_pct;
    // effective grid shape, used only to steer coordinates
    int shape_rows;
    int shape_cols;
    int words_sent;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 0;
    end

    grid_ray_free_space_trace #(
        .MAX_ROWS (GRID_SIDE),
        .MAX_COLS (GRID_SIDE)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .start_row   (start_row),
        .start_col   (start_col),
        .end_row     (end_row),
        .end_col     (end_col),
        .write_value (write_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cell_value  (cell_value),
        .status      (status),
        .cells_freed (cells_freed),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    grid_ray_free_space_trace_chk #(
        .MAX_ROWS (GRID_SIDE),
        .MAX_COLS (GRID_SIDE)
    ) u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .start_row     (start_row),
        .start_col     (start_col),
        .end_row       (end_row),
        .end_col       (end_col),
        .write_value   (write_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cell_value    (cell_value),
        .status        (status),
        .cells_freed   (cells_freed),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .blocked_count (blocked_count),
        .range_count   (range_count)
    );

    // receiver: stalls at random per cycle, never with a zero chance
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // hard stop well beyond the slowest legal run (clearing pass included)
    initial
    begin
        #12_000_000;
        $display("grid_ray_free_space_trace: mismatch");
        $finish;
    end

    // one input word; valid stays high after acceptance so that the next
    // word can follow at once, an idle gap lowers it first
    task automatic send_word(logic [1:0] m, logic [7:0] sr, logic [7:0] sc,
                             logic [7:0] er, logic [7:0] ec, logic [7:0] wv);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= m;
        start_row   <= sr;
        start_col   <= sc;
        end_row     <= er;
        end_col     <= ec;
        write_value <= wv;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
    endtask

    // one register write; cfg_valid is lowered by the caller after the batch
    task automatic write_reg(logic [CFGI_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_grid_shape(int rows, int cols);
        write_reg(REG_ROWS, CFG_W'(rows));
        write_reg(REG_COLS, CFG_W'(cols));
        cfg_valid <= 1'b0;
        // registers above the grid side act as the full side
        shape_rows = (rows > GRID_SIDE) ? GRID_SIDE : rows;
        shape_cols = (cols > GRID_SIDE) ? GRID_SIDE : cols;
    endtask

    // close a phase: no word in flight, every result back, block idle
    task automatic drain_words();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // in-range coordinate, mostly in a small corner so that writes and
    // traces keep meeting each other; sometimes anywhere or on the last line
    function automatic logic [7:0] pick_coord(int limit);
        int roll;
        int win;
        roll = $urandom_range(99);
        win = (limit < 24) ? limit : 24;
        if (limit <= 0)
            return 8'($urandom_range(255));
        if (roll < 70)
            return 8'($urandom_range(win - 1));
        if (roll < 90)
            return 8'($urandom_range(limit - 1));
        return 8'(limit - 1);
    endfunction

    // out-of-range coordinate where the shape leaves room for one
    function automatic logic [7:0] pick_outside(int limit);
        if (limit >= GRID_SIDE)
            return 8'($urandom_range(255));
        return 8'($urandom_range(255, limit));
    endfunction

    task automatic send_random_word();
        int roll;
        logic [1:0] m;
        logic [7:0] sr, sc, er, ec, wv;
        roll = $urandom_range(99);
        sr = pick_coord(shape_rows);
        sc = pick_coord(shape_cols);
        er = pick_coord(shape_rows);
        ec = pick_coord(shape_cols);
        wv = 8'($urandom_range(255));
        if (roll < 30)
        begin
            m = MODE_WRITE;
            // bias written values toward obstacles, free and unknown
            case ($urandom_range(3))
                0: wv = 8'($urandom_range(127, 1));
                1: wv = CELL_FREE;
                2: wv = CELL_UNKNOWN;
                default: ;
            endcase
        end
        else if (roll < 55)
        begin
            m = MODE_READ;
        end
        else if (roll < 90)
        begin
            m = MODE_TRACE;
        end
        else
        begin
            // noise: any mode, unused one included, one coordinate pushed out
            m = 2'($urandom_range(3));
            case ($urandom_range(3))
                0: sr = pick_outside(shape_rows);
                1: sc = pick_outside(shape_cols);
                2: er = pick_outside(shape_rows);
                default: ec = pick_outside(shape_cols);
            endcase
        end
        send_word(m, sr, sc, er, ec, wv);
    endtask

    initial
    begin
        int rows, cols, count;
        idle_mix_t mix;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        mode        = MODE_WRITE;
        start_row   = '0;
        start_col   = '0;
        end_row     = '0;
        end_col     = '0;
        write_value = '0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_ROWS;
        cfg_data    = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        shape_rows  = GRID_SIDE;
        shape_cols  = GRID_SIDE;
        words_sent  = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed words on the reset shape; the first handshake waits out
        // the clearing pass
        send_word(MODE_READ,  8'd0,   8'd0,   8'd0,   8'd0,   8'h00); // unknown after reset
        send_word(MODE_WRITE, 8'd255, 8'd255, 8'd0,   8'd0,   8'd127);
        send_word(MODE_READ,  8'd255, 8'd255, 8'd0,   8'd0,   8'h00);
        send_word(MODE_WRITE, 8'd0,   8'd0,   8'd0,   8'd0,   8'h80); // most negative
        send_word(MODE_READ,  8'd0,   8'd0,   8'd0,   8'd0,   8'h00);
        // start equal to end visits nothing
        send_word(MODE_TRACE, 8'd7,   8'd7,   8'd7,   8'd7,   8'h00);
        // first row but for its end cell, a negative cell is not an obstacle
        send_word(MODE_TRACE, 8'd0,   8'd0,   8'd0,   8'd255, 8'h00);
        send_word(MODE_READ,  8'd0,   8'd200, 8'd0,   8'd0,   8'h00);
        // first column but for its end cell, walked upward, rows major
        send_word(MODE_TRACE, 8'd255, 8'd0,   8'd0,   8'd0,   8'h00);
        // equal spans, columns major
        send_word(MODE_TRACE, 8'd10,  8'd10,  8'd20,  8'd20,  8'h00);
        // obstacle in the path, then a trace starting on it
        send_word(MODE_WRITE, 8'd30,  8'd33,  8'd0,   8'd0,   8'd5);
        send_word(MODE_TRACE, 8'd30,  8'd30,  8'd30,  8'd40,  8'h00);
        send_word(MODE_TRACE, 8'd30,  8'd33,  8'd30,  8'd40,  8'h00);
        // shallow forward and steep backward lines
        send_word(MODE_TRACE, 8'd40,  8'd40,  8'd45,  8'd60,  8'h00);
        send_word(MODE_TRACE, 8'd60,  8'd45,  8'd40,  8'd40,  8'h00);
        // obstacle on the end cell does not stop the trace
        send_word(MODE_WRITE, 8'd50,  8'd55,  8'd0,   8'd0,   8'd1);
        send_word(MODE_TRACE, 8'd50,  8'd50,  8'd50,  8'd55,  8'h00);
        send_word(MODE_NONE,  8'hA5,  8'h5A,  8'hC3,  8'h3C,  8'h96);
        drain_words();

        // directed range checks on a 20 x 30 grid, old cells under a new stride
        set_grid_shape(20, 30);
        send_word(MODE_READ,  8'd19,  8'd29,  8'd0,   8'd0,   8'h00);
        send_word(MODE_READ,  8'd20,  8'd0,   8'd0,   8'd0,   8'h00);
        send_word(MODE_WRITE, 8'd0,   8'd30,  8'd0,   8'd0,   8'd7);
        send_word(MODE_TRACE, 8'd0,   8'd0,   8'd20,  8'd0,   8'h00); // end outside
        send_word(MODE_TRACE, 8'd19,  8'd30,  8'd0,   8'd0,   8'h00); // start outside
        send_word(MODE_TRACE, 8'd19,  8'd29,  8'd0,   8'd0,   8'h00);
        send_word(MODE_NONE,  8'h5A,  8'hA5,  8'h3C,  8'hC3,  8'h69);
        drain_words();

        // random phases: shapes from empty to clamped, every idle mix
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:  begin rows = 256; cols = 256; count = 100; mix = IDLE_NONE;     end
                1:  begin rows = 16;  cols = 16;  count = 110; mix = IDLE_SENDER;   end
                2:  begin rows = 511; cols = 511; count = 90;  mix = IDLE_RECEIVER; end
                3:  begin rows = 12;  cols = 200; count = 90;  mix = IDLE_BOTH;     end
                4:  begin rows = 200; cols = 12;  count = 90;  mix = IDLE_NONE;     end
                5:  begin rows = 1;   cols = 1;   count = 40;  mix = IDLE_BOTH;     end
                6:  begin rows = 0;   cols = 0;   count = 25;  mix = IDLE_SENDER;   end
                7:  begin rows = 2;   cols = 256; count = 60;  mix = IDLE_RECEIVER; end
                8:  begin rows = 257; cols = 3;   count = 60;  mix = IDLE_SENDER;   end
                9:  begin rows = 24;  cols = 24;  count = 110; mix = IDLE_BOTH;     end
                default:
                    begin rows = 256; cols = 256; count = 75;  mix = IDLE_RECEIVER; end
            endcase
            // indexes without a register must leave the shape alone
            if (p == 5)
            begin
                write_reg(REG_SPARE2, 9'h155);
                write_reg(REG_SPARE3, 9'h0AA);
            end
            set_grid_shape(rows, cols);
            case (mix)
                IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                IDLE_SENDER:   begin send_idle_pct = 67; recv_stall_pct = 0;  end
                IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default:       begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            repeat (count)
                send_random_word();
            drain_words();
        end

        // longest trace latency after the last result
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d words over %0d grid shapes, sender and receiver idling mixed",
                 words_sent, PHASES + 2);
        $display("run: %0d traces stopped by obstacles, %0d words out of range",
                 blocked_count, range_count);
        if (fail_count == 0 && outstanding == 0)
            $display("grid_ray_free_space_trace: match");
        else
            $display("grid_ray_free_space_trace: mismatch");
        $finish;
    end

endmodule
